// ----- hw/rtl/vector_angle_and_magnitude_top_defines.svh -----
`ifndef VECTOR_ANGLE_AND_MAGNITUDE_TOP_DEFINES_SVH
`define VECTOR_ANGLE_AND_MAGNITUDE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define VAM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define VAM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define VAM_ASSERT_SAME(lbl, ante, cons, msg)
`define VAM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/vam_pkg.sv -----
package vam_pkg;
	localparam int unsigned ANGLE_W = 9;
	localparam int unsigned K_W = 7;
	localparam int unsigned K_MAX = 89;
	localparam logic [ANGLE_W-1:0] ANG_0 = 9'd0;
	localparam logic [ANGLE_W-1:0] ANG_45 = 9'd45;
	localparam logic [ANGLE_W-1:0] ANG_90 = 9'd90;
	localparam logic [ANGLE_W-1:0] ANG_180 = 9'd180;
	localparam logic [ANGLE_W-1:0] ANG_270 = 9'd270;
	localparam logic [ANGLE_W-1:0] ANG_360 = 9'd360;
	localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;
	localparam logic [63:0] STEP_Q62 = (PI_Q62 + 64'd90) / 64'd180;

	function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	function automatic logic [63:0] term_div(input logic [63:0] t, input int n);
		logic [63:0] r;
		case (n)
			1: r = t / 64'd6;
			2: r = t / 64'd20;
			3: r = t / 64'd42;
			4: r = t / 64'd72;
			5: r = t / 64'd110;
			6: r = t / 64'd156;
			7: r = t / 64'd210;
			8: r = t / 64'd272;
			9: r = t / 64'd342;
			10: r = t / 64'd420;
			11: r = t / 64'd506;
			12: r = t / 64'd600;
			13: r = t / 64'd702;
			14: r = t / 64'd812;
			default: r = 64'd0;
		endcase
		return r;
	endfunction

	function automatic logic [90:0][63:0] build_sin();
		logic [90:0][63:0] tbl;
		logic [63:0] r, r2, term, sum;
		for (int d = 0; d <= 90; d++) begin
			r = STEP_Q62 * 64'(d);
			r2 = q62_mul(r, r);
			term = r;
			sum = r;
			for (int n = 1; n <= 14; n++) begin
				term = term_div(q62_mul(term, r2), n);
				if (n % 2 == 1) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
			tbl[d] = sum;
		end
		return tbl;
	endfunction

	localparam logic [90:0][63:0] SIN_TBL = build_sin();
endpackage

// ----- hw/rtl/vam_in_if.sv -----
interface vam_in_if #(parameter int COORD_WIDTH = 16);
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] vec_x;
	logic signed [COORD_WIDTH-1:0] vec_y;
	modport source (output valid, output vec_x, output vec_y, input ready);
	modport sink (input valid, input vec_x, input vec_y, output ready);
endinterface

// ----- hw/rtl/vam_out_if.sv -----
interface vam_out_if #(parameter int COORD_WIDTH = 16);
	logic valid;
	logic ready;
	logic [vam_pkg::ANGLE_W-1:0] heading;
	logic [COORD_WIDTH-1:0] magnitude;
	modport source (output valid, output heading, output magnitude, input ready);
	modport sink (input valid, input heading, input magnitude, output ready);
endinterface

// ----- hw/rtl/vector_angle_and_magnitude_top.sv -----
// Vector angle and magnitude: takes one (vec_x, vec_y) transaction per cycle while ready is
// high and returns heading (whole degrees, 0..359) and magnitude (floor of the length). A
// transaction passes max(16, COORD_WIDTH + 3) register stages; throughput is one vector per
// cycle while the output is not stalled. The angle comes from a seven-step binary search
// over a sine table, each step two stages (partial products, then wide compare); the
// magnitude from a square root that resolves one result bit per stage. A full stage holds
// while the one ahead is full and stalled, so bubbles are squeezed out and input stays open
// until the whole pipeline is full.
`include "vector_angle_and_magnitude_top_defines.svh"
module vector_angle_and_magnitude_top #(
	parameter int COORD_WIDTH = 16
) (
	input logic clk,
	input logic arst_n,
	vam_in_if.sink vec_in,
	vam_out_if.source res_out
);
	localparam int W = COORD_WIDTH;
	localparam int ANG_ST = 15;
	localparam int SQ_FIRST = 3;
	localparam int SQ_LAST = W + 2;
	localparam int F = (SQ_LAST > ANG_ST) ? SQ_LAST : ANG_ST;
	localparam int KW = vam_pkg::K_W;

	logic [F:0] v_s;
	logic [F:0] en;
	logic [W-1:0] ax_s [F+1];
	logic [W-1:0] ay_s [F+1];
	logic [F:0] xneg_s;
	logic [F:0] yneg_s;
	logic [KW-1:0] k_s [F+1];
	logic [W+31:0] pch_s [F+1];
	logic [W+31:0] pcl_s [F+1];
	logic [W+31:0] psh_s [F+1];
	logic [W+31:0] psl_s [F+1];
	logic [2*W-1:0] rem_s [F+1];
	logic [2*W-1:0] res_s [F+1];
	logic [vam_pkg::ANGLE_W-1:0] ang_s [F+1];

	assign vec_in.ready = en[0];
	assign res_out.valid = v_s[F];
	assign res_out.heading = ang_s[F];
	assign res_out.magnitude = res_s[F][W-1:0];

	for (genvar i = 0; i <= F; i++) begin : g_st
		if (i == F) begin : g_en_last
			assign en[i] = !v_s[i] || res_out.ready;
		end else begin : g_en
			assign en[i] = !v_s[i] || en[i+1];
		end

		if (i == 0) begin : g_in
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[0] <= 1'b0;
				end else if (en[0]) begin
					v_s[0] <= vec_in.valid;
				end
			end
			always_ff @(posedge clk) begin
				if (en[0]) begin
					ax_s[0] <= vec_in.vec_x[W-1] ? (~vec_in.vec_x + 1'b1) : vec_in.vec_x;
					ay_s[0] <= vec_in.vec_y[W-1] ? (~vec_in.vec_y + 1'b1) : vec_in.vec_y;
					xneg_s[0] <= vec_in.vec_x[W-1];
					yneg_s[0] <= vec_in.vec_y[W-1];
					k_s[0] <= '0;
					pch_s[0] <= '0;
					pcl_s[0] <= '0;
					psh_s[0] <= '0;
					psl_s[0] <= '0;
					rem_s[0] <= '0;
					res_s[0] <= '0;
					ang_s[0] <= vam_pkg::ANG_0;
				end
			end
		end else begin : g_work
			localparam int T = (i - 1) / 2;
			localparam bit IS_PROD = (i <= 13) && (i % 2 == 1);
			localparam bit IS_CMP = (i >= 2) && (i <= 14) && (i % 2 == 0);
			localparam bit IS_SQ = (i >= SQ_FIRST) && (i <= SQ_LAST);
			localparam int J = (IS_SQ) ? (W + 2 - i) : 0;
			localparam logic [KW-1:0] KBIT = KW'(1) << (6 - ((T > 6) ? 6 : T));
			localparam logic [2*W-1:0] SQBIT = (2*W)'(1) << (2 * J);

			logic [KW-1:0] cand;
			logic [6:0] si;
			logic [6:0] ci;
			logic [63:0] sv;
			logic [63:0] cv;
			logic [W+63:0] lhs;
			logic [W+63:0] rhs;
			logic [2*W-1:0] trial;
			logic [vam_pkg::ANGLE_W-1:0] kk;
			logic [vam_pkg::ANGLE_W-1:0] ang_c;

			always_comb begin
				cand = k_s[i-1] | KBIT;
				si = (cand > KW'(vam_pkg::K_MAX)) ? 7'd0 : cand;
				ci = 7'd90 - si;
				sv = vam_pkg::SIN_TBL[si];
				cv = vam_pkg::SIN_TBL[ci];
				lhs = {pch_s[i-1], 32'd0} + (W+64)'(pcl_s[i-1]);
				rhs = {psh_s[i-1], 32'd0} + (W+64)'(psl_s[i-1]);
				trial = res_s[i-1] + SQBIT;
				kk = (ax_s[i-1] == ay_s[i-1]) ? vam_pkg::ANG_45
					: vam_pkg::ANGLE_W'(k_s[i-1]);
				if (ax_s[i-1] == '0) begin
					ang_c = (ay_s[i-1] == '0) ? vam_pkg::ANG_0
						: (yneg_s[i-1] ? vam_pkg::ANG_270 : vam_pkg::ANG_90);
				end else if (ay_s[i-1] == '0) begin
					ang_c = xneg_s[i-1] ? vam_pkg::ANG_180 : vam_pkg::ANG_0;
				end else if (!xneg_s[i-1] && !yneg_s[i-1]) begin
					ang_c = kk;
				end else if (xneg_s[i-1] && !yneg_s[i-1]) begin
					ang_c = vam_pkg::ANG_180 - kk;
				end else if (xneg_s[i-1]) begin
					ang_c = vam_pkg::ANG_180 + kk;
				end else begin
					ang_c = (kk == vam_pkg::ANG_0) ? vam_pkg::ANG_0 : vam_pkg::ANG_360 - kk;
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[i] <= 1'b0;
				end else if (en[i]) begin
					v_s[i] <= v_s[i-1];
				end
			end

			always_ff @(posedge clk) begin
				if (en[i]) begin
					ax_s[i] <= ax_s[i-1];
					ay_s[i] <= ay_s[i-1];
					xneg_s[i] <= xneg_s[i-1];
					yneg_s[i] <= yneg_s[i-1];
					k_s[i] <= k_s[i-1];
					pch_s[i] <= pch_s[i-1];
					pcl_s[i] <= pcl_s[i-1];
					psh_s[i] <= psh_s[i-1];
					psl_s[i] <= psl_s[i-1];
					rem_s[i] <= rem_s[i-1];
					res_s[i] <= res_s[i-1];
					ang_s[i] <= ang_s[i-1];
					if (IS_PROD) begin
						pch_s[i] <= (W+32)'(ay_s[i-1]) * (W+32)'(cv[63:32]);
						pcl_s[i] <= (W+32)'(ay_s[i-1]) * (W+32)'(cv[31:0]);
						psh_s[i] <= (W+32)'(ax_s[i-1]) * (W+32)'(sv[63:32]);
						psl_s[i] <= (W+32)'(ax_s[i-1]) * (W+32)'(sv[31:0]);
					end
					if (IS_CMP) begin
						if (cand <= KW'(vam_pkg::K_MAX) && lhs >= rhs) begin
							k_s[i] <= cand;
						end
					end
					if (i == 1) begin
						rem_s[i] <= (2*W)'(ax_s[i-1]) * (2*W)'(ax_s[i-1]);
						res_s[i] <= (2*W)'(ay_s[i-1]) * (2*W)'(ay_s[i-1]);
					end
					if (i == 2) begin
						rem_s[i] <= rem_s[i-1] + res_s[i-1];
						res_s[i] <= '0;
					end
					if (IS_SQ) begin
						if (rem_s[i-1] >= trial) begin
							rem_s[i] <= rem_s[i-1] - trial;
							res_s[i] <= (res_s[i-1] >> 1) + SQBIT;
						end else begin
							res_s[i] <= res_s[i-1] >> 1;
						end
					end
					if (i == ANG_ST) begin
						ang_s[i] <= ang_c;
					end
				end
			end
		end
	end

	`VAM_ASSERT_SAME(a_angle_range, res_out.valid, res_out.heading < vam_pkg::ANG_360, "angle out of range")
	`VAM_ASSERT_SAME(a_full_when_closed, !vec_in.ready, &v_s, "input closed with a free stage")
	`VAM_ASSERT_NEXT(a_hold_result, res_out.valid && !res_out.ready, res_out.valid && $stable(res_out.magnitude), "stalled result dropped")
endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
module tb_top;
	localparam int CW = 16;

	typedef struct packed {
		logic [vam_pkg::ANGLE_W-1:0] heading;
		logic [CW-1:0] magnitude;
	} direction_t;

	logic clk;
	logic arst_n;
	vam_in_if #(.COORD_WIDTH(CW)) vec_in();
	vam_out_if #(.COORD_WIDTH(CW)) res_out();

	vector_angle_and_magnitude_top #(.COORD_WIDTH(CW)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.vec_in(vec_in.sink),
		.res_out(res_out.source)
	);

	logic [63:0] sine_q62 [0:90];
	direction_t pending_dirs[$];
	int mismatches;
	int burst_left;
	int stall_mode;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic direction_t predict_direction(input logic signed [CW-1:0] x,
			input logic signed [CW-1:0] y);
		direction_t r;
		logic [63:0] ax;
		logic [63:0] ay;
		logic [127:0] lhs;
		logic [127:0] rhs;
		int k;
		int ang;
		ax = x < 0 ? 64'(-int'(x)) : 64'(x);
		ay = y < 0 ? 64'(-int'(y)) : 64'(y);
		k = 0;
		if (ax == 0) begin
			ang = (ay == 0) ? 0 : (y < 0 ? 270 : 90);
		end else if (ay == 0) begin
			ang = (x < 0) ? 180 : 0;
		end else begin
			if (ax == ay) begin
				k = 45;
			end else begin
				for (int d = 89; d >= 1; d--) begin
					lhs = {64'd0, ay} * {64'd0, sine_q62[90-d]};
					rhs = {64'd0, ax} * {64'd0, sine_q62[d]};
					if (lhs >= rhs) begin
						k = d;
						break;
					end
				end
			end
			if (x > 0 && y > 0) ang = k;
			else if (x < 0 && y > 0) ang = 180 - k;
			else if (x < 0) ang = 180 + k;
			else ang = (k == 0) ? 0 : 360 - k;
		end
		r.heading = vam_pkg::ANGLE_W'(ang);
		r.magnitude = CW'(int_sqrt(ax * ax + ay * ay));
		return r;
	endfunction

	initial begin
		logic [63:0] step;
		logic [63:0] rr;
		logic [63:0] r2;
		logic [63:0] term;
		logic [63:0] sum;
		step = (64'hC90FDAA22168C235 + 64'd90) / 64'd180;
		for (int d = 0; d <= 90; d++) begin
			rr = step * 64'(d);
			r2 = fx_mul(rr, rr);
			term = rr;
			sum = rr;
			for (int n = 1; n <= 14; n++) begin
				term = fx_mul(term, r2) / 64'((2 * n) * (2 * n + 1));
				if (n % 2 == 1) sum = sum - term;
				else sum = sum + term;
			end
			sine_q62[d] = sum;
		end
	end

	task automatic send_vector(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y);
		if (burst_left == 0) begin
			vec_in.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
			burst_left = $urandom_range(1, 20);
		end
		vec_in.valid <= 1'b1;
		vec_in.vec_x <= x;
		vec_in.vec_y <= y;
		pending_dirs.push_back(predict_direction(x, y));
		@(posedge clk);
		while (!vec_in.ready) @(posedge clk);
		@(negedge clk);
		burst_left--;
	endtask

	always @(negedge clk) begin
		if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
		case (stall_mode)
			0: res_out.ready <= 1'b1;
			1: res_out.ready <= ($urandom_range(0, 3) != 0);
			default: res_out.ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	always @(posedge clk) begin
		direction_t want;
		if (arst_n && res_out.valid && res_out.ready) begin
			if (pending_dirs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected transaction angle=%0d mag=%0d",
					res_out.heading, res_out.magnitude);
			end else begin
				want = pending_dirs.pop_front();
				if (res_out.heading !== want.heading
						|| res_out.magnitude !== want.magnitude) begin
					mismatches++;
					if (mismatches <= 10) $display("mismatch: exp angle=%0d mag=%0d got angle=%0d mag=%0d",
						want.heading, want.magnitude, res_out.heading, res_out.magnitude);
				end
			end
		end
	end

	task automatic test_axes_and_extremes();
		send_vector(0, 0);
		send_vector(100, 0);
		send_vector(0, 100);
		send_vector(-100, 0);
		send_vector(0, -100);
		send_vector(-32768, -32768);
		send_vector(32767, 32767);
		send_vector(-32768, 32767);
		send_vector(32767, -32768);
		send_vector(-32768, 0);
		send_vector(0, -32768);
		send_vector(7, 7);
		send_vector(-7, 7);
		send_vector(-7, -7);
		send_vector(7, -7);
		send_vector(32767, -1);
		send_vector(32767, 1);
		send_vector(-32767, -1);
		send_vector(1, 32767);
		send_vector(-1, -32767);
		send_vector(-32768, 1);
	endtask

	task automatic test_random_full_range();
		for (int i = 0; i < 600; i++)
			send_vector(CW'($urandom), CW'($urandom));
	endtask

	task automatic test_random_small_and_diagonal();
		int a;
		for (int i = 0; i < 300; i++) begin
			a = $urandom_range(1, 32767);
			case ($urandom_range(0, 2))
				0: send_vector(CW'(int'($urandom_range(0, 15)) - 8),
					CW'(int'($urandom_range(0, 15)) - 8));
				1: send_vector(CW'($urandom_range(0, 1) ? a : -a),
					CW'($urandom_range(0, 1) ? a : -a));
				default: send_vector(CW'($urandom_range(0, 1) ? a : -a),
					CW'(int'($urandom_range(0, 6)) - 3));
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		vec_in.valid = 1'b0;
		vec_in.vec_x = '0;
		vec_in.vec_y = '0;
		res_out.ready = 1'b0;
		mismatches = 0;
		burst_left = 0;
		stall_mode = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_axes_and_extremes();
		test_random_full_range();
		test_random_small_and_diagonal();
		vec_in.valid <= 1'b0;
		while (pending_dirs.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end
endmodule
